// File: design/csvd_pkg.sv
// ============================================================================
// csvd_pkg: shared types and constants for the CSV decimal field parser
// Item and result payload types, ASCII codes and numeric limits.
// ============================================================================
package csvd_pkg;

	// Payload widths
	localparam int unsigned MANT_W = 28;
	localparam int unsigned ACC_W  = 27;
	localparam int unsigned FRAC_W = 3;
	localparam int unsigned IDX_W  = 3;

	// Default sizing
	localparam int unsigned MAX_CHARS_DEF  = 8;
	localparam int unsigned MAX_FIELDS_DEF = 8;

	// Numeric limits
	localparam logic [ACC_W-1:0]  MANT_MAX = ACC_W'(99999999);
	localparam logic [FRAC_W-1:0] FRAC_MAX = FRAC_W'(7);

	// ASCII codes
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// Input item
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_message;
	} in_item_t;

	// Result item
	typedef struct packed {
		logic signed [MANT_W-1:0] value_mantissa;
		logic [FRAC_W-1:0]        fraction_digits;
		logic [IDX_W-1:0]         field_index;
		logic                     well_formed;
		logic                     line_end;
	} result_t;

	// Parser status seen by the top level
	typedef struct packed {
		logic in_number;
		logic stopped;
		logic fields_zero;
	} core_status_t;

endpackage

// File: design/csvd_in_stage.sv
// ============================================================================
// csvd_in_stage: input register
// Holds one accepted item until the field core consumes it.
// ============================================================================
module csvd_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic               advance,
	input  csvd_pkg::in_item_t item_in,
	output logic               valid_s1,
	output csvd_pkg::in_item_t item_s1
);
	import csvd_pkg::*;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_in;
		end
	end

endmodule

// File: design/csvd_field_core.sv
// ============================================================================
// csvd_field_core: field state and per-byte step logic
// Accumulates the open field and builds the result when a field closes.
// ============================================================================
module csvd_field_core #(
	parameter int unsigned MAX_CHARS  = csvd_pkg::MAX_CHARS_DEF,
	parameter int unsigned MAX_FIELDS = csvd_pkg::MAX_FIELDS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  csvd_pkg::in_item_t     item,
	output logic                   emit,
	output csvd_pkg::result_t      res,
	output csvd_pkg::core_status_t status
);
	import csvd_pkg::*;

	localparam int unsigned CW = $clog2(MAX_CHARS + 1);
	localparam int unsigned FW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

	// Field state
	logic [CW-1:0]     char_count_q;
	logic [ACC_W-1:0]  mantissa_acc_q;
	logic [FRAC_W-1:0] frac_count_q;
	logic              point_seen_q;
	logic              is_negative_q;
	logic              bad_field_q;
	logic              in_number_q;
	logic [FW-1:0]     fields_done_q;
	logic              parse_stopped_q;

	// Updated field state after storing this byte
	logic [CW-1:0]     cc_u;
	logic [ACC_W-1:0]  acc_u;
	logic [FRAC_W-1:0] frac_u;
	logic              point_u;
	logic              neg_u;
	logic              bad_u;
	logic              innum_u;

	logic              is_digit;
	logic              is_sep;
	logic              is_store;
	logic              line_end;
	logic              last_field;
	logic [3:0]        digit;
	logic [30:0]       prod;
	logic [MANT_W-1:0] mag;

	// Store one character into the open field
	always_comb begin
		is_digit = (item.rx_byte >= CH_ZERO) && (item.rx_byte <= CH_NINE);
		is_sep   = (item.rx_byte == CH_COMMA) || (item.rx_byte == CH_LF) ||
		           (item.rx_byte == CH_CR);
		is_store = is_digit || (item.rx_byte == CH_POINT) || (item.rx_byte == CH_MINUS);
		// ASCII digits sit at 0x30..0x39, so the low nibble is the digit
		digit    = item.rx_byte[3:0];
		// x10 as shift-add, then the new digit
		prod     = (31'(mantissa_acc_q) << 3) + (31'(mantissa_acc_q) << 1) +
		           31'(digit);

		cc_u    = char_count_q;
		acc_u   = mantissa_acc_q;
		frac_u  = frac_count_q;
		point_u = point_seen_q;
		neg_u   = is_negative_q;
		bad_u   = bad_field_q;
		innum_u = in_number_q;

		if (!parse_stopped_q && is_store && (char_count_q < CW'(MAX_CHARS))) begin
			if (item.rx_byte == CH_MINUS) begin
				if (char_count_q == '0) begin
					neg_u = 1'b1;
				end else begin
					bad_u = 1'b1;
				end
			end else if (item.rx_byte == CH_POINT) begin
				if (point_seen_q) begin
					bad_u = 1'b1;
				end else begin
					point_u = 1'b1;
				end
			end else if (!point_seen_q || (frac_count_q < FRAC_MAX)) begin
				acc_u = (prod > 31'(MANT_MAX)) ? MANT_MAX : prod[ACC_W-1:0];
				if (point_seen_q) begin
					frac_u = frac_count_q + FRAC_W'(1);
				end
			end
			cc_u    = char_count_q + CW'(1);
			innum_u = 1'b1;
		end
	end

	// Field close: separator or end of message with something stored
	always_comb begin
		emit       = step && !parse_stopped_q && innum_u && (is_sep || item.end_of_message);
		line_end   = is_sep ? (item.rx_byte != CH_COMMA) : 1'b1;
		last_field = (fields_done_q == FW'(MAX_FIELDS - 1));
		mag        = {1'b0, acc_u};

		res.value_mantissa  = bad_u ? '0 : (neg_u ? $signed('0 - mag) : $signed(mag));
		res.fraction_digits = bad_u ? '0 : frac_u;
		res.field_index     = IDX_W'(fields_done_q);
		res.well_formed     = !bad_u;
		res.line_end        = line_end;
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q    <= '0;
			mantissa_acc_q  <= '0;
			frac_count_q    <= '0;
			point_seen_q    <= 1'b0;
			is_negative_q   <= 1'b0;
			bad_field_q     <= 1'b0;
			in_number_q     <= 1'b0;
			fields_done_q   <= '0;
			parse_stopped_q <= 1'b0;
		end else if (step) begin
			if (item.end_of_message || emit) begin
				char_count_q   <= '0;
				mantissa_acc_q <= '0;
				frac_count_q   <= '0;
				point_seen_q   <= 1'b0;
				is_negative_q  <= 1'b0;
				bad_field_q    <= 1'b0;
				in_number_q    <= 1'b0;
			end else begin
				char_count_q   <= cc_u;
				mantissa_acc_q <= acc_u;
				frac_count_q   <= frac_u;
				point_seen_q   <= point_u;
				is_negative_q  <= neg_u;
				bad_field_q    <= bad_u;
				in_number_q    <= innum_u;
			end
			if (item.end_of_message) begin
				fields_done_q   <= '0;
				parse_stopped_q <= 1'b0;
			end else if (emit) begin
				fields_done_q <= fields_done_q + FW'(1);
				if (last_field) begin
					parse_stopped_q <= 1'b1;
				end
			end
		end
	end

	assign status.in_number   = in_number_q;
	assign status.stopped     = parse_stopped_q;
	assign status.fields_zero = (fields_done_q == '0);

endmodule

// File: design/csvd_out_stage.sv
// ============================================================================
// csvd_out_stage: result register
// Holds one finished result until the receiver takes it.
// ============================================================================
module csvd_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  csvd_pkg::result_t res_in,
	input  logic              stall,
	output logic              valid_q,
	output csvd_pkg::result_t res_q,
	output logic              free
);
	import csvd_pkg::*;

	// Room for a new result: empty, or the current one leaves this cycle
	assign free = !valid_q || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule

// File: design/csv_decimal_field_parser.sv
// ============================================================================
// csv_decimal_field_parser: comma/line separated decimal field parser
// Takes one ASCII byte per item and emits each closed field as a signed
// mantissa with its count of fractional digits.
// ============================================================================
//
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+-------------------------------
//   input    | item_valid   | item_stall   | item   (rx_byte, end_of_message)
//   output   | result_valid | result_stall | result (mantissa, frac, index..)
//
// One item per cycle while item_stall is low; an item waits in the input
// register, and a field it closes loads the result register and result_valid.
// The step is one x10 shift-add, a saturating compare and a negate.
// Reset clears the field state, field count and both stage valids.
// A stall on the result side backs up into item_stall only when the input
// register holds a byte that would have to wait for the result register.
//
module csv_decimal_field_parser #(
	parameter int unsigned MAX_CHARS  = csvd_pkg::MAX_CHARS_DEF,
	parameter int unsigned MAX_FIELDS = csvd_pkg::MAX_FIELDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  csvd_pkg::in_item_t item,
	output logic               result_valid,
	input  logic               result_stall,
	output csvd_pkg::result_t  result
);
	import csvd_pkg::*;

	logic         valid_s1;
	in_item_t     item_s1;
	logic         out_free;
	logic         advance;
	logic         emit;
	result_t      res_next;
	core_status_t status;

	// Stage control
	assign advance    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;

	csvd_in_stage u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (item_valid && !item_stall),
		.advance (advance),
		.item_in (item),
		.valid_s1(valid_s1),
		.item_s1 (item_s1)
	);

	csvd_field_core #(
		.MAX_CHARS (MAX_CHARS),
		.MAX_FIELDS(MAX_FIELDS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.step  (advance),
		.item  (item_s1),
		.emit  (emit),
		.res   (res_next),
		.status(status)
	);

	csvd_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (emit),
		.res_in (res_next),
		.stall  (result_stall),
		.valid_q(result_valid),
		.res_q  (result),
		.free   (out_free)
	);

	// Checks
	a_bad_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.well_formed |->
			result.value_mantissa == '0 && result.fraction_digits == '0)
		else $error("malformed field with nonzero value");

	a_mant_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.value_mantissa <= 28'sd99999999 &&
			result.value_mantissa >= -28'sd99999999)
		else $error("mantissa out of range");

	a_eom_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.end_of_message |=>
			!status.in_number && !status.stopped && status.fields_zero)
		else $error("state not cleared after end of message");

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !item_stall)
		else $error("input stalled with empty input register");

endmodule
